[hw/rtl/e131pc_pkg.sv]
// shared types and constants for the e1.31 packet checker and channel extractor
// no dependencies
`timescale 1ns / 1ps

package e131pc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned STATUS_W  = 4;
  localparam int unsigned START_W   = 10;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 10;
  localparam int unsigned CHIDX_W   = 3;

  // first dmx slot byte of the payload
  localparam int unsigned DMX_DATA_OFFSET = 126;

  // byte positions inside the udp payload
  localparam logic [WORD_W-1:0] POS_PRE_0      = 16'd0;
  localparam logic [WORD_W-1:0] POS_PRE_1      = 16'd1;
  localparam logic [WORD_W-1:0] POS_POST_0     = 16'd2;
  localparam logic [WORD_W-1:0] POS_POST_1     = 16'd3;
  localparam logic [WORD_W-1:0] POS_ID_FIRST   = 16'd4;
  localparam logic [WORD_W-1:0] POS_ID_LAST    = 16'd15;
  localparam logic [WORD_W-1:0] POS_FRAMING_HI = 16'd38;
  localparam logic [WORD_W-1:0] POS_FRAMING_LO = 16'd39;
  localparam logic [WORD_W-1:0] POS_UNIV_HI    = 16'd113;
  localparam logic [WORD_W-1:0] POS_UNIV_LO    = 16'd114;
  localparam logic [WORD_W-1:0] POS_DMP_HI     = 16'd115;
  localparam logic [WORD_W-1:0] POS_DMP_LO     = 16'd116;
  localparam logic [WORD_W-1:0] POS_VECTOR     = 16'd117;
  localparam logic [WORD_W-1:0] POS_COUNT_HI   = 16'd123;
  localparam logic [WORD_W-1:0] POS_COUNT_LO   = 16'd124;
  localparam logic [WORD_W-1:0] POS_STARTCODE  = 16'd125;
  localparam logic [WORD_W-1:0] POS_SAT        = 16'hFFFF;

  localparam logic [BYTE_W-1:0] PREAMBLE_LO  = 8'h10;
  localparam logic [WORD_W-1:0] FLAGS_BIAS   = 16'h7000;
  localparam logic [WORD_W-1:0] FRAMING_BASE = 16'd38;
  localparam logic [WORD_W-1:0] DMP_BASE     = 16'd115;
  localparam logic [WORD_W-1:0] MIN_DMX_SIZE = 16'd129;
  localparam logic [BYTE_W-1:0] VECTOR_A     = 8'h02;
  localparam logic [BYTE_W-1:0] VECTOR_B     = 8'h04;
  localparam logic [BYTE_W-1:0] SC_NULL      = 8'h00;
  localparam logic [BYTE_W-1:0] SC_ALT       = 8'h04;

  // acn packet identifier "ASC-E1.17" and three zero bytes
  localparam logic [BYTE_W-1:0] ACN_ID [12] = '{
    8'h41, 8'h53, 8'h43, 8'h2d, 8'h45, 8'h31, 8'h2e, 8'h31, 8'h37, 8'h00, 8'h00, 8'h00
  };

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 4'd0,
    ST_SHORT     = 4'd1,
    ST_PREAMBLE  = 4'd2,
    ST_POSTAMBLE = 4'd3,
    ST_ID        = 4'd4,
    ST_FRAMING   = 4'd5,
    ST_DMP       = 4'd6,
    ST_VECTOR    = 4'd7,
    ST_STARTCODE = 4'd8,
    ST_COUNT     = 4'd9,
    ST_WINDOW    = 4'd10
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_CHANNEL = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } cfg_reg_t;

  // per-packet summary handed to the result drain
  typedef struct packed {
    status_t             status;
    logic [WORD_W-1:0]   universe;
  } pkt_sum_t;

endpackage

[hw/rtl/e131pc_drain.sv]
// result drain: holds one packet's status and window snapshot and sends its results
// depends on e131pc_pkg
`timescale 1ns / 1ps

module e131pc_drain #(
  parameter int unsigned MAX_WINDOW_CHANNELS = 8
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   load,
  input  e131pc_pkg::pkt_sum_t                                   load_sum,
  input  logic [$clog2(MAX_WINDOW_CHANNELS+1)-1:0]               load_len,
  input  logic [MAX_WINDOW_CHANNELS-1:0][e131pc_pkg::BYTE_W-1:0] load_win,
  output logic                                                   free,
  output logic                                                   out_valid,
  input  logic                                                   out_ready,
  output logic                                                   out_item_kind,
  output logic [e131pc_pkg::STATUS_W-1:0]                        out_status,
  output logic [e131pc_pkg::WORD_W-1:0]                          out_universe,
  output logic [e131pc_pkg::BYTE_W-1:0]                          out_channel_value,
  output logic [e131pc_pkg::CHIDX_W-1:0]                         out_channel_index,
  output logic                                                   out_last_of_run
);
  import e131pc_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_WINDOW_CHANNELS + 1);
  localparam int unsigned IDX_W = (MAX_WINDOW_CHANNELS > 1) ? $clog2(MAX_WINDOW_CHANNELS) : 1;

  logic                                   busy_r;
  logic [LEN_W-1:0]                       idx_r;
  logic [LEN_W-1:0]                       len_r;
  pkt_sum_t                               sum_r;
  logic [MAX_WINDOW_CHANNELS-1:0][BYTE_W-1:0] win_r;

  logic             fire;
  logic             last;
  logic [LEN_W-1:0] ch_pos;
  logic [IDX_W-1:0] rd_idx;

  // item 0 is the status, item k>0 carries window channel k-1
  assign ch_pos = idx_r - LEN_W'(1);
  assign rd_idx = ch_pos[IDX_W-1:0];
  assign last   = (idx_r == len_r);
  assign fire   = busy_r && out_ready;
  assign free   = !busy_r || (fire && last);

  assign out_valid         = busy_r;
  assign out_item_kind     = (idx_r != '0);
  assign out_status        = (idx_r == '0) ? sum_r.status : ST_OK;
  assign out_universe      = sum_r.universe;
  assign out_channel_value = (idx_r == '0) ? '0 : win_r[rd_idx];
  assign out_channel_index = (idx_r == '0) ? '0 : CHIDX_W'(32'(ch_pos));
  assign out_last_of_run   = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (fire) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r <= load_sum;
      len_r <= load_len;
      win_r <= load_win;
    end
  end

endmodule

[hw/rtl/e131_packet_check_and_channel_extract.sv]
// top level of the e1.31 packet checker and channel window extractor
// depends on e131pc_pkg and e131pc_drain
`timescale 1ns / 1ps

// Takes one E1.31 UDP payload byte per cycle and checks the preamble, postamble and ACN
// identifier as the bytes pass, latching the length words, vector, start code, universe,
// value count and the bytes of the channel window set by start_channel and channel_count.
// On the byte flagged end_of_packet one status transaction is produced (first failure in
// protocol order), followed by one transaction per window channel when the packet is good.
// Ordinary bytes are accepted every cycle. The status transaction is offered the cycle after
// the final byte is taken and the channel transactions follow one per cycle while out_ready
// is high. A final byte is held off only while the previous packet's results (the status and,
// for a good packet, one transaction per window channel) are still being taken from the output
// drain, so with out_ready held high the rate stays at one byte per cycle for packets of at
// least the window length plus one bytes.
// The user must write configuration only while no packet is in flight; it is not enforced.
module e131_packet_check_and_channel_extract #(
  parameter int unsigned MAX_WINDOW_CHANNELS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_write_en,
  input  logic [e131pc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [e131pc_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [e131pc_pkg::BYTE_W-1:0]         in_data_byte,
  input  logic                                  in_end_of_packet,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_item_kind,
  output logic [e131pc_pkg::STATUS_W-1:0]       out_status,
  output logic [e131pc_pkg::WORD_W-1:0]         out_universe,
  output logic [e131pc_pkg::BYTE_W-1:0]         out_channel_value,
  output logic [e131pc_pkg::CHIDX_W-1:0]        out_channel_index,
  output logic                                  out_last_of_run
);
  import e131pc_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_WINDOW_CHANNELS + 1);
  localparam int unsigned IDX_W = (MAX_WINDOW_CHANNELS > 1) ? $clog2(MAX_WINDOW_CHANNELS) : 1;
  localparam int unsigned OFF_W = START_W + 1;

  // configuration
  logic [START_W-1:0] start_channel_r;
  logic [COUNT_W-1:0] channel_count_r;

  // per-packet state
  logic [WORD_W-1:0] pos_r;
  status_t           first_err_r, first_err_nxt;
  logic [WORD_W-1:0] framing_r, framing_nxt;
  logic [WORD_W-1:0] dmp_r, dmp_nxt;
  logic [WORD_W-1:0] universe_r, universe_nxt;
  logic [WORD_W-1:0] count_r, count_nxt;
  logic [BYTE_W-1:0] vector_r, vector_nxt;
  logic [BYTE_W-1:0] sc_r, sc_nxt;
  logic [MAX_WINDOW_CHANNELS-1:0][BYTE_W-1:0] win_r, win_nxt;

  logic              accept;
  logic              drain_free;
  status_t           byte_err;
  status_t           final_st;
  logic [LEN_W-1:0]  wlen;
  logic [OFF_W-1:0]  win_off;
  logic [WORD_W-1:0] win_diff;
  logic              in_win;
  logic [WORD_W-1:0] size;
  logic [WORD_W-1:0] need_framing;
  logic [WORD_W-1:0] need_dmp;
  logic [WORD_W+1:0] win_end;
  logic [3:0]        id_idx;
  pkt_sum_t          sum;
  logic [LEN_W-1:0]  run_len;

  assign in_ready = !in_end_of_packet || drain_free;
  assign accept   = in_valid && in_ready;

  assign wlen = (32'(channel_count_r) > MAX_WINDOW_CHANNELS) ?
                LEN_W'(MAX_WINDOW_CHANNELS) : LEN_W'(channel_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_channel_r <= START_W'(1);
      channel_count_r <= COUNT_W'(3);
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_CHANNEL: start_channel_r <= cfg_data[START_W-1:0];
        REG_CHANNEL_COUNT: channel_count_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // header checks for this byte
  assign id_idx = pos_r[3:0] - 4'd4;

  always_comb begin
    byte_err = ST_OK;
    if ((pos_r == POS_PRE_0 && in_data_byte != 8'h00) ||
        (pos_r == POS_PRE_1 && in_data_byte != PREAMBLE_LO)) begin
      byte_err = ST_PREAMBLE;
    end else if ((pos_r == POS_POST_0 || pos_r == POS_POST_1) && in_data_byte != 8'h00) begin
      byte_err = ST_POSTAMBLE;
    end else if (pos_r >= POS_ID_FIRST && pos_r <= POS_ID_LAST &&
                 in_data_byte != ACN_ID[id_idx]) begin
      byte_err = ST_ID;
    end
  end

  assign first_err_nxt = (first_err_r != ST_OK) ? first_err_r : byte_err;

  // header field capture
  always_comb begin
    framing_nxt  = framing_r;
    dmp_nxt      = dmp_r;
    universe_nxt = universe_r;
    count_nxt    = count_r;
    vector_nxt   = vector_r;
    sc_nxt       = sc_r;
    if (pos_r == POS_FRAMING_HI) framing_nxt[15:8]  = in_data_byte;
    if (pos_r == POS_FRAMING_LO) framing_nxt[7:0]   = in_data_byte;
    if (pos_r == POS_UNIV_HI)    universe_nxt[15:8] = in_data_byte;
    if (pos_r == POS_UNIV_LO)    universe_nxt[7:0]  = in_data_byte;
    if (pos_r == POS_DMP_HI)     dmp_nxt[15:8]      = in_data_byte;
    if (pos_r == POS_DMP_LO)     dmp_nxt[7:0]       = in_data_byte;
    if (pos_r == POS_VECTOR)     vector_nxt         = in_data_byte;
    if (pos_r == POS_COUNT_HI)   count_nxt[15:8]    = in_data_byte;
    if (pos_r == POS_COUNT_LO)   count_nxt[7:0]     = in_data_byte;
    if (pos_r == POS_STARTCODE)  sc_nxt             = in_data_byte;
  end

  // window capture, start channel zero lands on the start code byte
  assign win_off  = OFF_W'(DMX_DATA_OFFSET - 1) + OFF_W'(start_channel_r);
  assign win_diff = pos_r - WORD_W'(win_off);
  assign in_win   = (pos_r >= WORD_W'(win_off)) && (win_diff < WORD_W'(wlen));

  always_comb begin
    win_nxt = win_r;
    if (in_win) begin
      win_nxt[win_diff[IDX_W-1:0]] = in_data_byte;
    end
  end

  // final status, first failure wins
  assign size         = (pos_r == POS_SAT) ? POS_SAT : pos_r + WORD_W'(1);
  assign need_framing = framing_nxt - FLAGS_BIAS + FRAMING_BASE;
  assign need_dmp     = dmp_nxt - FLAGS_BIAS + DMP_BASE;
  assign win_end      = (WORD_W+2)'(DMX_DATA_OFFSET - 1) + (WORD_W+2)'(start_channel_r) +
                        (WORD_W+2)'(wlen);

  always_comb begin
    priority if (size < WORD_W'(DMX_DATA_OFFSET)) begin
      final_st = ST_SHORT;
    end else if (first_err_nxt != ST_OK) begin
      final_st = first_err_nxt;
    end else if (size < need_framing) begin
      final_st = ST_FRAMING;
    end else if (size < need_dmp) begin
      final_st = ST_DMP;
    end else if (vector_nxt != VECTOR_A && vector_nxt != VECTOR_B) begin
      final_st = ST_VECTOR;
    end else if (sc_nxt != SC_NULL && sc_nxt != SC_ALT) begin
      final_st = ST_STARTCODE;
    end else if (count_nxt == '0) begin
      final_st = ST_COUNT;
    end else if (size < MIN_DMX_SIZE) begin
      final_st = ST_SHORT;
    end else if (win_end > (WORD_W+2)'(size)) begin
      final_st = ST_WINDOW;
    end else begin
      final_st = ST_OK;
    end
  end

  assign sum.status   = final_st;
  assign sum.universe = universe_nxt;
  assign run_len      = (final_st == ST_OK) ? wlen : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      first_err_r <= ST_OK;
      framing_r   <= '0;
      dmp_r       <= '0;
      universe_r  <= '0;
      count_r     <= '0;
      vector_r    <= '0;
      sc_r        <= '0;
    end else if (accept) begin
      if (in_end_of_packet) begin
        pos_r       <= '0;
        first_err_r <= ST_OK;
        framing_r   <= '0;
        dmp_r       <= '0;
        universe_r  <= '0;
        count_r     <= '0;
        vector_r    <= '0;
        sc_r        <= '0;
      end else begin
        pos_r       <= (pos_r == POS_SAT) ? POS_SAT : pos_r + WORD_W'(1);
        first_err_r <= first_err_nxt;
        framing_r   <= framing_nxt;
        dmp_r       <= dmp_nxt;
        universe_r  <= universe_nxt;
        count_r     <= count_nxt;
        vector_r    <= vector_nxt;
        sc_r        <= sc_nxt;
      end
    end
  end

  // window bytes persist across packets
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  e131pc_drain #(
    .MAX_WINDOW_CHANNELS(MAX_WINDOW_CHANNELS)
  ) u_drain (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (accept && in_end_of_packet),
    .load_sum          (sum),
    .load_len          (run_len),
    .load_win          (win_nxt),
    .free              (drain_free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_item_kind     (out_item_kind),
    .out_status        (out_status),
    .out_universe      (out_universe),
    .out_channel_value (out_channel_value),
    .out_channel_index (out_channel_index),
    .out_last_of_run   (out_last_of_run)
  );

endmodule
